// ===== hdl/cpbc_pkg.sv =====
// cpbc_pkg: shared types and constants for the box culling core
// holds the plane word layout and the register index codes
// no dependencies
`default_nettype none

package cpbc_pkg;

   localparam int IN_W           = 16;  // corner port width
   localparam int EXT_W          = 15;  // extent port width
   localparam int NORM_W         = 16;  // q1.14 normal component width
   localparam int FRAC_BITS      = 14;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 64;
   localparam int CNT_W          = 3;
   localparam int AXES           = 3;
   localparam int MAX_PLANES_DEF = 6;
   localparam int COORD_BITS_DEF = 16;
   localparam int PIPE_DEPTH     = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_ZERO  = 3'd1;

   // bits 63:48 offset, 47:32 nz, 31:16 ny, 15:0 nx
   typedef struct packed {
      logic signed [NORM_W-1:0] d;
      logic signed [NORM_W-1:0] nz;
      logic signed [NORM_W-1:0] ny;
      logic signed [NORM_W-1:0] nx;
   } plane_type;

endpackage

`default_nettype wire

// ===== hdl/convex_planes_box_cull_core.sv =====
// convex_planes_box_cull_core: top level of the box versus convex volume cull
// instantiates cpbc_regs, cpbc_corner and one cpbc_lane per plane
// depends on cpbc_pkg
//
//  channel   ports                                   handshake
//  request   req_corner_*, req_extent_*              start high, busy low
//  response  rsp_box_intersects                      rsp_valid, one cycle
//  csr       csr_index, csr_data                     csr_we, no wait
//
// one box per cycle; each word passes these registered stages in order:
// corner add, normal products, sum and compare, plane reduction.
// busy is never raised since every stage advances each cycle.
// reset clears valid bits and the plane registers (plane count zero: all boxes pass).
// the receiver cannot stall, so there is no back pressure anywhere.
`default_nettype none

module convex_planes_box_cull_core import cpbc_pkg::*; #(
   parameter int MAX_PLANES = MAX_PLANES_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [IN_W-1:0]       req_corner_x,
   input  wire logic [IN_W-1:0]       req_corner_y,
   input  wire logic [IN_W-1:0]       req_corner_z,
   input  wire logic [EXT_W-1:0]      req_extent_x,
   input  wire logic [EXT_W-1:0]      req_extent_y,
   input  wire logic [EXT_W-1:0]      req_extent_z,
   output logic                       rsp_valid,
   output logic                       rsp_box_intersects,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   plane_type                     planes [MAX_PLANES];
   logic [MAX_PLANES-1:0]         active;
   logic                          accept;
   logic                          v1;
   logic [AXES-1:0][COORD_BITS:0] lo, hi;
   logic [MAX_PLANES-1:0]         over;
   logic                          v2_ff, v3_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_hit_ff, rsp_hit_in;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   cpbc_regs #(
      .MAX_PLANES (MAX_PLANES)
   ) u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .planes    (planes),
      .active    (active)
   );

   cpbc_corner #(
      .COORD_BITS (COORD_BITS)
   ) u_corner (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .corner    ({req_corner_z, req_corner_y, req_corner_x}),
      .extent    ({req_extent_z, req_extent_y, req_extent_x}),
      .out_valid (v1),
      .lo        (lo),
      .hi        (hi)
   );

   for (genvar i = 0; i < MAX_PLANES; i++) begin : g_lane
      cpbc_lane #(
         .COORD_BITS (COORD_BITS)
      ) u_lane (
         .clock (clock),
         .lo    (lo),
         .hi    (hi),
         .plane (planes[i]),
         .over  (over[i])
      );
   end

   // rejected when some active plane has the whole box over it
   assign rsp_hit_in = ~|(over & active);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v2_ff        <= v1;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff <= rsp_hit_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_box_intersects = rsp_hit_ff;

   a_word_out: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##PIPE_DEPTH rsp_valid)
      else $error("accepted word did not reach the response");

   a_word_in: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, PIPE_DEPTH))
      else $error("response without an accepted word");

   a_mid_pipe: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> $past(v1, 2))
      else $error("pipeline valid bits out of step");

endmodule

`default_nettype wire

// ===== hdl/cpbc_regs.sv =====
// cpbc_regs: plane count and plane registers of the box culling core
// decodes the csr write port and builds the active plane mask
// depends on cpbc_pkg
`default_nettype none

module cpbc_regs import cpbc_pkg::*; #(
   parameter int MAX_PLANES = MAX_PLANES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output plane_type                  planes [MAX_PLANES],
   output logic [MAX_PLANES-1:0]      active
);

   logic [CNT_W-1:0] count_ff;
   plane_type        plane_ff [MAX_PLANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < MAX_PLANES; i++) begin
            plane_ff[i] <= '0;
         end
      end else if (csr_we) begin
         if (csr_index == CSR_PLANE_COUNT) begin
            count_ff <= csr_data[CNT_W-1:0];
         end
         for (int i = 0; i < MAX_PLANES; i++) begin
            if (int'(csr_index) == int'(CSR_PLANE_ZERO) + i) begin
               plane_ff[i] <= plane_type'(csr_data);
            end
         end
      end
   end

   // a count above the lane count simply enables every lane
   always_comb begin
      for (int i = 0; i < MAX_PLANES; i++) begin
         planes[i] = plane_ff[i];
         active[i] = int'(count_ff) > i;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/cpbc_corner.sv =====
// cpbc_corner: first pipeline stage, forms low and high box coordinates
// one adder per axis, registered with the stage valid bit
// depends on cpbc_pkg
`default_nettype none

module cpbc_corner import cpbc_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   input  wire logic [AXES-1:0][IN_W-1:0]  corner,
   input  wire logic [AXES-1:0][EXT_W-1:0] extent,
   output logic                          out_valid,
   output logic [AXES-1:0][COORD_BITS:0] lo,
   output logic [AXES-1:0][COORD_BITS:0] hi
);

   localparam int WIDE_W = 32;

   logic                          valid_ff;
   logic [AXES-1:0][COORD_BITS:0] lo_ff, lo_in;
   logic [AXES-1:0][COORD_BITS:0] hi_ff, hi_in;
   logic [WIDE_W-1:0]             c_wide [AXES];
   logic [WIDE_W-1:0]             e_wide [AXES];
   logic [COORD_BITS-1:0]         c_cut  [AXES];
   logic [COORD_BITS-2:0]         e_cut  [AXES];

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         c_wide[a] = {{(WIDE_W-IN_W){corner[a][IN_W-1]}}, corner[a]};
         e_wide[a] = {{(WIDE_W-EXT_W){1'b0}}, extent[a]};
         c_cut[a]  = c_wide[a][COORD_BITS-1:0];
         e_cut[a]  = e_wide[a][COORD_BITS-2:0];
         lo_in[a]  = {c_cut[a][COORD_BITS-1], c_cut[a]};
         hi_in[a]  = {c_cut[a][COORD_BITS-1], c_cut[a]} + {2'b00, e_cut[a]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end

   assign out_valid = valid_ff;
   assign lo        = lo_ff;
   assign hi        = hi_ff;

endmodule

`default_nettype wire

// ===== hdl/cpbc_lane.sv =====
// cpbc_lane: per-plane test, nearest corner product stage then sum and compare
// the corner with least dot product is picked per axis by the normal's sign
// depends on cpbc_pkg
`default_nettype none

module cpbc_lane import cpbc_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic [AXES-1:0][COORD_BITS:0] lo,
   input  wire logic [AXES-1:0][COORD_BITS:0] hi,
   input  wire plane_type                     plane,
   output logic                               over
);

   localparam int P_W    = COORD_BITS + 1;
   localparam int PROD_W = NORM_W + P_W;
   localparam int D_W    = NORM_W + FRAC_BITS;
   localparam int SUM_W  = (PROD_W + 2 > D_W + 1) ? PROD_W + 2 : D_W + 1;

   logic signed [NORM_W-1:0] norm [AXES];
   logic signed [P_W-1:0]    pick [AXES];
   logic signed [PROD_W-1:0] prod_ff [AXES];
   logic signed [PROD_W-1:0] prod_in [AXES];
   logic signed [SUM_W-1:0]  dot;
   logic signed [SUM_W-1:0]  bound;
   logic                     over_ff, over_in;

   always_comb begin
      norm[0] = plane.nx;
      norm[1] = plane.ny;
      norm[2] = plane.nz;
      for (int a = 0; a < AXES; a++) begin
         // negative normal: the high coordinate gives the smaller product
         pick[a]    = norm[a][NORM_W-1] ? signed'(hi[a]) : signed'(lo[a]);
         prod_in[a] = PROD_W'(norm[a]) * PROD_W'(pick[a]);
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < AXES; a++) begin
         prod_ff[a] <= prod_in[a];
      end
   end

   always_comb begin
      dot     = SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]) + SUM_W'(prod_ff[2]);
      bound   = SUM_W'(signed'({plane.d, {FRAC_BITS{1'b0}}}));
      over_in = dot > bound;
   end

   always_ff @(posedge clock) begin
      over_ff <= over_in;
   end

   assign over = over_ff;

endmodule

`default_nettype wire
